>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Needs a clk_i and an active-low rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcw assertion failed");
// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/tcw_pkg.sv
// Package of the text console cell writer: geometry, codes, types, address helpers.
// Used by tcw_sweep and the top level; depends on nothing.
package tcw_pkg;

  localparam int TERMINALS      = 8;
  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS_PER_TERM = COLUMNS * ROWS;
  localparam int TOTAL_CELLS    = TERMINALS * CELLS_PER_TERM;
  localparam int MOVE_CELLS     = (ROWS - 1) * COLUMNS;

  localparam int AddrW = $clog2(TOTAL_CELLS);
  localparam int CntW  = $clog2(TOTAL_CELLS + 1);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);
  localparam int TermW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int CellW = 16;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam int         TAB_STOP     = 8;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_READ   = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_COLOUR = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_WAIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP
  } state_e;

  typedef enum logic {
    OP_FILL,
    OP_SCROLL
  } sweep_op_e;

  typedef struct packed {
    logic             valid;
    sweep_op_e        op;
    logic [AddrW-1:0] base;
    logic [CntW-1:0]  count;
    logic [7:0]       attr;
  } sweep_req_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [CellW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  function automatic logic [AddrW-1:0] cell_addr(input logic [TermW-1:0] t,
                                                 input logic [RowW-1:0]  r,
                                                 input logic [ColW-1:0]  c);
    return AddrW'((int'(t) * ROWS + int'(r)) * COLUMNS + int'(c));
  endfunction

  function automatic logic [AddrW-1:0] term_base(input logic [TermW-1:0] t);
    return AddrW'(int'(t) * CELLS_PER_TERM);
  endfunction

endpackage

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address collision; no dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tcw_sweep.sv
// Sweep engine: fills a range of the screen RAM or scrolls one terminal up a row.
// Depends on tcw_pkg; drives the RAM ports while a sweep runs.
`include "assert_macros.svh"

module tcw_sweep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::sweep_req_t          req_i,
  input  logic [tcw_pkg::CellW-1:0]    rdata_i,
  output tcw_pkg::ram_req_t            ram_o,
  output logic                         done_o
);

  logic                        run_q, run_d;
  logic [tcw_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [tcw_pkg::CntW-1:0]    count_q, count_d;
  logic [tcw_pkg::AddrW-1:0]   addr_q, addr_d;
  tcw_pkg::sweep_op_e          op_q, op_d;
  logic [7:0]                  attr_q, attr_d;
  logic                        wr_pend_q, wr_pend_d;
  logic                        wr_ram_q, wr_ram_d;
  logic [tcw_pkg::AddrW-1:0]   wr_addr_q, wr_addr_d;
  logic                        from_ram;

  // Each running cycle reads the source cell (scroll only) and queues one write;
  // the write is issued from registers so the registered read data can feed it.
  always_comb begin
    run_d     = run_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    addr_d    = addr_q;
    op_d      = op_q;
    attr_d    = attr_q;
    from_ram  = (op_q == tcw_pkg::OP_SCROLL) &&
                (cnt_q < tcw_pkg::CntW'(tcw_pkg::MOVE_CELLS));
    wr_pend_d = 1'b0;
    wr_ram_d  = 1'b0;
    wr_addr_d = addr_q;

    ram_o.re    = 1'b0;
    ram_o.raddr = addr_q + tcw_pkg::AddrW'(tcw_pkg::COLUMNS);

    if (run_q) begin
      ram_o.re  = from_ram;
      wr_pend_d = 1'b1;
      wr_ram_d  = from_ram;
      wr_addr_d = addr_q;
      cnt_d     = cnt_q + tcw_pkg::CntW'(1);
      addr_d    = addr_q + tcw_pkg::AddrW'(1);
      if (cnt_q == count_q - tcw_pkg::CntW'(1)) begin
        run_d = 1'b0;
      end
    end else if (req_i.valid) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      count_d = req_i.count;
      addr_d  = req_i.base;
      op_d    = req_i.op;
      attr_d  = req_i.attr;
    end

    ram_o.we    = wr_pend_q;
    ram_o.waddr = wr_addr_q;
    ram_o.wdata = wr_ram_q ? rdata_i : {attr_q, tcw_pkg::BLANK_CHAR};
  end

  assign done_o = wr_pend_q && !run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      wr_pend_q <= 1'b0;
      op_q      <= tcw_pkg::OP_FILL;
    end else begin
      run_q     <= run_d;
      wr_pend_q <= wr_pend_d;
      op_q      <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    count_q   <= count_d;
    addr_q    <= addr_d;
    attr_q    <= attr_d;
    wr_ram_q  <= wr_ram_d;
    wr_addr_q <= wr_addr_d;
  end

  `TCW_ASSERT_IMP(a_req_when_free, req_i.valid, !run_q && !wr_pend_q)
  `TCW_ASSERT_IMP(a_copy_has_read, wr_pend_q && wr_ram_q, $past(ram_o.re))
  `TCW_ASSERT_NXT(a_done_drains, done_o, !run_q && !wr_pend_q)

endmodule

>>> hw/rtl/text_console_cell_writer_top.sv
// Top level of the text console cell writer: command decode, cursor state, result beat.
// Depends on tcw_pkg, tcw_sweep and tcw_ram.
//
// A command beat is taken when start is high and busy is low; its one result beat
// appears on the result ports with done_o high for a single cycle and cannot be held
// off. After reset the block is busy while the screen RAM is swept to blanks one cell
// per cycle. Set cursor, set colour, unknown codes and put character without a scroll
// give their result from the execute state; read cell of an on-screen cell passes
// through a further read state for the registered RAM read. Clear and a put character
// that scrolls wait in the sweep state: the single write port of the screen RAM
// moves or blanks one cell per cycle. A new command may be given in the cycle its
// predecessor's result is shown.
`include "assert_macros.svh"

module text_console_cell_writer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command_i,
  input  logic [2:0] terminal_i,
  input  logic [7:0] character_i,
  input  logic [6:0] column_i,
  input  logic [4:0] row_i,
  input  logic [3:0] foreground_i,
  input  logic [3:0] background_i,
  output logic       done_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o
);

  tcw_pkg::state_e state_q, state_d;

  logic [2:0] cmd_q;
  logic [2:0] term_q;
  logic [7:0] char_q;
  logic [6:0] col_in_q;
  logic [4:0] row_in_q;
  logic [3:0] fg_q;
  logic [3:0] bg_q;

  logic [tcw_pkg::ColW-1:0] cur_col_q [tcw_pkg::TERMINALS];
  logic [tcw_pkg::RowW-1:0] cur_row_q [tcw_pkg::TERMINALS];
  logic [7:0]               attr_q    [tcw_pkg::TERMINALS];

  logic [7:0] res_char_q, res_char_d;
  logic [7:0] res_attr_q, res_attr_d;
  logic [6:0] res_col_q, res_col_d;
  logic [4:0] res_row_q, res_row_d;
  logic       done_q, done_d;

  logic                      accept;
  logic                      term_ok;
  logic [tcw_pkg::TermW-1:0] t_sel;
  logic [tcw_pkg::ColW-1:0]  x;
  logic [tcw_pkg::RowW-1:0]  y;
  logic [7:0]                a;
  logic [tcw_pkg::ColW:0]    nx;
  logic [tcw_pkg::RowW:0]    ny;
  logic [tcw_pkg::ColW-1:0]  wx;
  logic                      cur_we;
  logic [tcw_pkg::ColW-1:0]  cur_col_new;
  logic [tcw_pkg::RowW-1:0]  cur_row_new;
  logic                      attr_we;
  logic [7:0]                attr_new;

  tcw_pkg::sweep_req_t       sweep_req;
  tcw_pkg::ram_req_t         sweep_ram;
  tcw_pkg::ram_req_t         own_ram;
  tcw_pkg::ram_req_t         ram_req;
  logic                      sweep_done;
  logic [tcw_pkg::CellW-1:0] rdata;

  assign busy   = (state_q != tcw_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign term_ok = (int'(term_q) < tcw_pkg::TERMINALS);
  assign t_sel   = term_ok ? tcw_pkg::TermW'(term_q) : '0;
  assign x       = cur_col_q[t_sel];
  assign y       = cur_row_q[t_sel];
  assign a       = attr_q[t_sel];

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    res_char_d  = res_char_q;
    res_attr_d  = res_attr_q;
    res_col_d   = res_col_q;
    res_row_d   = res_row_q;
    cur_we      = 1'b0;
    cur_col_new = x;
    cur_row_new = y;
    attr_we     = 1'b0;
    attr_new    = a;
    nx          = {1'b0, x};
    ny          = {1'b0, y};
    wx          = x;

    sweep_req.valid = 1'b0;
    sweep_req.op    = tcw_pkg::OP_FILL;
    sweep_req.base  = tcw_pkg::term_base(t_sel);
    sweep_req.count = tcw_pkg::CntW'(tcw_pkg::CELLS_PER_TERM);
    sweep_req.attr  = a;

    own_ram.we    = 1'b0;
    own_ram.waddr = tcw_pkg::cell_addr(t_sel, y, x);
    own_ram.wdata = {a, char_q};
    own_ram.re    = 1'b0;
    own_ram.raddr = tcw_pkg::cell_addr(t_sel, tcw_pkg::RowW'(row_in_q),
                                       tcw_pkg::ColW'(col_in_q));

    case (state_q)
      tcw_pkg::ST_INIT: begin
        sweep_req.valid = 1'b1;
        sweep_req.base  = '0;
        sweep_req.count = tcw_pkg::CntW'(tcw_pkg::TOTAL_CELLS);
        sweep_req.attr  = tcw_pkg::DEFAULT_ATTR;
        state_d         = tcw_pkg::ST_INIT_WAIT;
      end
      tcw_pkg::ST_INIT_WAIT: begin
        if (sweep_done) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        state_d    = tcw_pkg::ST_IDLE;
        done_d     = 1'b1;
        res_char_d = '0;
        res_attr_d = '0;
        if (!term_ok) begin
          res_col_d = '0;
          res_row_d = '0;
        end else begin
          case (tcw_pkg::cmd_e'(cmd_q))
            tcw_pkg::CMD_PUT: begin
              case (char_q)
                tcw_pkg::CH_NEWLINE: begin
                  nx = '0;
                  ny = ny + (tcw_pkg::RowW+1)'(1);
                end
                tcw_pkg::CH_RETURN: begin
                  nx = '0;
                end
                tcw_pkg::CH_TAB: begin
                  nx = ({1'b0, x} + (tcw_pkg::ColW+1)'(tcw_pkg::TAB_STOP)) &
                       ~(tcw_pkg::ColW+1)'(tcw_pkg::TAB_STOP - 1);
                end
                tcw_pkg::CH_BACKSPACE: begin
                  if (x != '0) begin
                    wx            = x - tcw_pkg::ColW'(1);
                    nx            = {1'b0, wx};
                    own_ram.we    = 1'b1;
                    own_ram.wdata = {a, tcw_pkg::BLANK_CHAR};
                  end
                end
                default: begin
                  own_ram.we = 1'b1;
                  nx         = {1'b0, x} + (tcw_pkg::ColW+1)'(1);
                end
              endcase
              own_ram.waddr = tcw_pkg::cell_addr(t_sel, y, wx);
              if (nx >= (tcw_pkg::ColW+1)'(tcw_pkg::COLUMNS)) begin
                nx = '0;
                ny = ny + (tcw_pkg::RowW+1)'(1);
              end
              // Leaving the bottom row: the cursor lands at the start of the new
              // bottom row and the screen moves up once the cell write is done.
              if (ny >= (tcw_pkg::RowW+1)'(tcw_pkg::ROWS)) begin
                ny              = (tcw_pkg::RowW+1)'(tcw_pkg::ROWS - 1);
                nx              = '0;
                sweep_req.valid = 1'b1;
                sweep_req.op    = tcw_pkg::OP_SCROLL;
                state_d         = tcw_pkg::ST_SWEEP;
                done_d          = 1'b0;
              end
              cur_we      = 1'b1;
              cur_col_new = tcw_pkg::ColW'(nx);
              cur_row_new = tcw_pkg::RowW'(ny);
            end
            tcw_pkg::CMD_READ: begin
              if ((int'(col_in_q) < tcw_pkg::COLUMNS) && (int'(row_in_q) < tcw_pkg::ROWS)) begin
                own_ram.re = 1'b1;
                state_d    = tcw_pkg::ST_READ;
                done_d     = 1'b0;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              sweep_req.valid = 1'b1;
              state_d         = tcw_pkg::ST_SWEEP;
              done_d          = 1'b0;
              cur_we          = 1'b1;
              cur_col_new     = '0;
              cur_row_new     = '0;
            end
            tcw_pkg::CMD_CURSOR: begin
              cur_we      = 1'b1;
              cur_col_new = (int'(col_in_q) < tcw_pkg::COLUMNS) ?
                            tcw_pkg::ColW'(col_in_q) : tcw_pkg::ColW'(tcw_pkg::COLUMNS - 1);
              cur_row_new = (int'(row_in_q) < tcw_pkg::ROWS) ?
                            tcw_pkg::RowW'(row_in_q) : tcw_pkg::RowW'(tcw_pkg::ROWS - 1);
            end
            tcw_pkg::CMD_COLOUR: begin
              attr_we  = 1'b1;
              attr_new = {bg_q, fg_q};
            end
            default: begin
            end
          endcase
          res_col_d = 7'(cur_col_new);
          res_row_d = 5'(cur_row_new);
        end
      end
      tcw_pkg::ST_READ: begin
        res_char_d = rdata[7:0];
        res_attr_d = rdata[15:8];
        done_d     = 1'b1;
        state_d    = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          done_d  = 1'b1;
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tcw_pkg::TERMINALS; i++) begin
        cur_col_q[i] <= '0;
        cur_row_q[i] <= tcw_pkg::RowW'(1);
        attr_q[i]    <= tcw_pkg::DEFAULT_ATTR;
      end
    end else begin
      if (cur_we) begin
        cur_col_q[t_sel] <= cur_col_new;
        cur_row_q[t_sel] <= cur_row_new;
      end
      if (attr_we) begin
        attr_q[t_sel] <= attr_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      term_q   <= terminal_i;
      char_q   <= character_i;
      col_in_q <= column_i;
      row_in_q <= row_i;
      fg_q     <= foreground_i;
      bg_q     <= background_i;
    end
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
    res_col_q  <= res_col_d;
    res_row_q  <= res_row_d;
  end

  // The sweep engine owns the RAM only while the controller waits on it.
  assign ram_req = ((state_q == tcw_pkg::ST_SWEEP) || (state_q == tcw_pkg::ST_INIT_WAIT)) ?
                   sweep_ram : own_ram;

  tcw_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sweep_req),
    .rdata_i (rdata),
    .ram_o   (sweep_ram),
    .done_o  (sweep_done)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CellW),
    .DEPTH (tcw_pkg::TOTAL_CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  assign done_o       = done_q;
  assign cell_char_o  = res_char_q;
  assign cell_attr_o  = res_attr_q;
  assign cursor_col_o = res_col_q;
  assign cursor_row_o = res_row_q;

  `TCW_ASSERT_IMP(a_result_when_idle, done_q, state_q == tcw_pkg::ST_IDLE)
  `TCW_ASSERT_NXT(a_no_result_after_accept, accept, !done_q)
  `TCW_ASSERT_IMP(a_cursor_on_screen, (state_q == tcw_pkg::ST_EXEC) && term_ok,
                  (int'(x) < tcw_pkg::COLUMNS) && (int'(y) < tcw_pkg::ROWS))

endmodule
